@@ rtl/scc_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants for the slope corridor compressor
// no dependencies; imported by the controller, datapath and arithmetic units
package scc_pkg;

  localparam int SLOPE_W = 48;
  localparam int TOL_W   = 31;

  localparam logic signed [SLOPE_W-1:0] SLOPE_MAX = {1'b0, {(SLOPE_W-1){1'b1}}};
  localparam logic signed [SLOPE_W-1:0] SLOPE_MIN = {1'b1, {(SLOPE_W-1){1'b0}}};
  localparam logic        [SLOPE_W-1:0] SLOPE_MAG = {1'b1, {(SLOPE_W-1){1'b0}}};

  localparam logic [TOL_W-1:0] TOL_RESET = 31'd10;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_SAMPLE = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_CALC,
    ST_FIT,
    ST_DECIDE,
    ST_EMIT_END,
    ST_EMIT_RAW
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic in_ready;
    logic start_calc;
    logic fit;
    logic narrow;
    logic emit_end;
    logic emit_raw;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    cmd_t cmd;
    logic in_fire;
    logic calc_done;
    logic brk;
    logic out_free;
  } dp_status_t;

endpackage

@@ rtl/scc_if.sv @@
`timescale 1ns / 1ps
// valid/ready channel interfaces for sample input and vertex output
// no dependencies
interface scc_in_if #(
  parameter int TIME_BITS  = 32,
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic [1:0]                   cmd;
  logic [TIME_BITS-1:0]         sample_time;
  logic signed [VALUE_BITS-1:0] sample_value;

  modport source (output valid, cmd, sample_time, sample_value, input ready);
  modport sink (input valid, cmd, sample_time, sample_value, output ready);
endinterface

interface scc_out_if #(
  parameter int TIME_BITS  = 32,
  parameter int VALUE_BITS = 32
);
  logic                         valid;
  logic                         ready;
  logic [TIME_BITS-1:0]         point_time;
  logic signed [VALUE_BITS-1:0] point_value;
  logic                         last;

  modport source (output valid, point_time, point_value, last, input ready);
  modport sink (input valid, point_time, point_value, last, output ready);
endinterface

@@ rtl/slope_corridor_compressor.sv @@
`timescale 1ns / 1ps
// Swinging-door style compressor for a timed sample stream. One transaction is
// handled at a time. A start item goes via dispatch and raw emit to its vertex.
// A sample or finish item goes via dispatch, calculation, fit and decide, then
// the emit states on a break or finish. The two bit-serial slope dividers each
// form NUM_BITS + SLOPE_FRAC_BITS quotient bits (NUM_BITS = max(VALUE_BITS + 1,
// 32) + 1) and run side by side with the serial multiplier for the fitted end.
// A finished vertex waits in an output register; a break puts out two vertices
// back to back when the sink keeps up. The tolerance register resets to 10.
// depends on scc_pkg, scc_if, scc_ctrl, scc_datapath
module slope_corridor_compressor import scc_pkg::*; #(
  parameter int TIME_BITS       = 32,
  parameter int VALUE_BITS      = 32,
  parameter int SLOPE_FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  scc_in_if.sink           in,
  scc_out_if.source        out,
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_wdata
);

  ctrl_cmd_t  cmd;
  dp_status_t status;

  scc_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .status(status),
    .cmd   (cmd)
  );

  scc_datapath #(
    .TIME_BITS      (TIME_BITS),
    .VALUE_BITS     (VALUE_BITS),
    .SLOPE_FRAC_BITS(SLOPE_FRAC_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .in       (in),
    .out      (out),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

@@ rtl/scc_div.sv @@
`timescale 1ns / 1ps
// bit-serial restoring divider: num * 2^FRAC_BITS / dvs, toward zero, saturated slope
// depends on scc_pkg
module scc_div import scc_pkg::*; #(
  parameter int TIME_BITS = 32,
  parameter int NUM_BITS  = 34,
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic signed [NUM_BITS-1:0] num,
  input  logic [TIME_BITS-1:0]       dvs,
  output logic                       done,
  output logic signed [SLOPE_W-1:0]  slope
);

  localparam int DW = NUM_BITS + FRAC_BITS;
  localparam int CW = $clog2(DW + 1);
  localparam int QW = (DW > SLOPE_W) ? DW : SLOPE_W;

  logic                 busy;
  logic [CW-1:0]        cnt;
  logic                 neg;
  logic [TIME_BITS-1:0] rem;
  logic [TIME_BITS-1:0] divisor;
  logic [DW-1:0]        dq;

  logic [NUM_BITS-1:0]  mag;
  logic [TIME_BITS:0]   trial;
  logic                 ge;
  logic [QW-1:0]        q_ext;
  logic                 sat;

  assign mag   = num[NUM_BITS-1] ? NUM_BITS'(-num) : NUM_BITS'(num);
  assign trial = {rem, dq[DW-1]};
  assign ge    = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(DW);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg     <= num[NUM_BITS-1];
      divisor <= dvs;
      rem     <= '0;
      dq      <= DW'(mag) << FRAC_BITS;
    end else if (busy) begin
      // remainder stays below the divisor, so its top bit is never needed
      rem <= ge ? TIME_BITS'(trial - {1'b0, divisor}) : TIME_BITS'(trial);
      dq  <= {dq[DW-2:0], ge};
    end
  end

  assign q_ext = QW'(dq);
  assign sat   = q_ext >= QW'(SLOPE_MAG);
  assign done  = !busy;

  always_comb begin
    if (neg) slope = sat ? SLOPE_MIN : -$signed(SLOPE_W'(q_ext));
    else     slope = sat ? SLOPE_MAX : $signed(SLOPE_W'(q_ext));
  end

endmodule

@@ rtl/scc_mul.sv @@
`timescale 1ns / 1ps
// bit-serial shift-add multiplier, one multiplier bit per cycle
// depends on scc_pkg
module scc_mul import scc_pkg::*; #(
  parameter int A_BITS = 48,
  parameter int B_BITS = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [A_BITS-1:0]        a,
  input  logic [B_BITS-1:0]        b,
  output logic                     done,
  output logic [A_BITS+B_BITS-1:0] product
);

  localparam int CW = $clog2(B_BITS + 1);

  logic              busy;
  logic [CW-1:0]     cnt;
  logic [A_BITS-1:0] mcand;
  logic [A_BITS-1:0] hi;
  logic [B_BITS-1:0] lo;
  logic [A_BITS:0]   psum;

  assign psum = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(B_BITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      hi    <= '0;
      lo    <= b;
    end else if (busy) begin
      hi <= psum[A_BITS:1];
      lo <= {psum[0], lo[B_BITS-1:1]};
    end
  end

  assign done    = !busy;
  assign product = {hi, lo};

endmodule

@@ rtl/scc_datapath.sv @@
`timescale 1ns / 1ps
// datapath: segment state, corridor, slope dividers, fit multiplier, output register
// depends on scc_pkg, scc_if, scc_div, scc_mul
module scc_datapath import scc_pkg::*; #(
  parameter int TIME_BITS       = 32,
  parameter int VALUE_BITS      = 32,
  parameter int SLOPE_FRAC_BITS = 16
) (
  input  logic             clk,
  input  logic             rst,
  scc_in_if.sink           in,
  scc_out_if.source        out,
  input  logic             cfg_we,
  input  logic [TOL_W-1:0] cfg_wdata,
  input  ctrl_cmd_t        cmd,
  output dp_status_t       status
);

  localparam int NUM_BITS  = ((VALUE_BITS + 1 > TOL_W + 1) ? VALUE_BITS + 1 : TOL_W + 1) + 1;
  localparam int PROD_BITS = SLOPE_W + TIME_BITS;
  localparam int QP_BITS   = PROD_BITS - SLOPE_FRAC_BITS;
  localparam int SUM_BITS  = ((QP_BITS > VALUE_BITS) ? QP_BITS : VALUE_BITS) + 2;
  localparam int MID_W     = SLOPE_W + 1;
  localparam logic signed [SUM_BITS-1:0] VAL_MAX_S =
    (SUM_BITS'(1) << (VALUE_BITS - 1)) - SUM_BITS'(1);
  localparam logic signed [SUM_BITS-1:0] VAL_MIN_S = -VAL_MAX_S - SUM_BITS'(1);

  // configuration and segment state
  logic [TOL_W-1:0]               tolerance;
  logic [TIME_BITS-1:0]           anchor_time;
  logic signed [VALUE_BITS-1:0]   anchor_value;
  logic [TIME_BITS-1:0]           last_time;
  logic signed [SLOPE_W-1:0]      slope_low;
  logic signed [SLOPE_W-1:0]      slope_high;

  // captured transaction and intermediate results
  logic [1:0]                     cmd_q;
  logic [TIME_BITS-1:0]           t_q;
  logic signed [VALUE_BITS-1:0]   v_q;
  logic signed [NUM_BITS-1:0]     dy;
  logic                           early_brk;
  logic                           mid_neg;
  logic signed [SLOPE_W-1:0]      lo_new;
  logic signed [SLOPE_W-1:0]      hi_new;
  logic signed [VALUE_BITS-1:0]   fit_value;

  // output register
  logic                           out_valid;
  logic [TIME_BITS-1:0]           point_time;
  logic signed [VALUE_BITS-1:0]   point_value;
  logic                           last;

  logic                           in_fire;
  logic                           is_finish;
  logic signed [NUM_BITS-1:0]     tol_s;
  logic signed [NUM_BITS-1:0]     num_lo;
  logic signed [NUM_BITS-1:0]     num_hi;
  logic [TIME_BITS-1:0]           seg_dt;
  logic [TIME_BITS-1:0]           fit_dt;
  logic signed [MID_W-1:0]        slope_sum;
  logic [MID_W-1:0]               slope_abs;
  logic [SLOPE_W-1:0]             mid_mag;
  logic                           lo_done;
  logic                           hi_done;
  logic                           mul_done;
  logic signed [SLOPE_W-1:0]      lo_slope;
  logic signed [SLOPE_W-1:0]      hi_slope;
  logic [PROD_BITS-1:0]           product;
  logic signed [SUM_BITS-1:0]     anchor_s;
  logic signed [SUM_BITS-1:0]     quot_s;
  logic signed [SUM_BITS-1:0]     fit_sum;

  assign in_fire   = in.valid && cmd.in_ready;
  assign is_finish = cmd_t'(cmd_q) == CMD_FINISH;

  assign tol_s  = $signed(NUM_BITS'(tolerance));
  assign num_lo = dy - tol_s;
  assign num_hi = dy + tol_s;
  assign seg_dt = t_q - anchor_time;
  assign fit_dt = last_time - anchor_time;

  // mid slope toward zero: magnitude of the sum, halved
  assign slope_sum = MID_W'(slope_low) + MID_W'(slope_high);
  assign slope_abs = slope_sum[MID_W-1] ? MID_W'(-slope_sum) : MID_W'(slope_sum);
  assign mid_mag   = slope_abs[MID_W-1:1];

  scc_div #(
    .TIME_BITS(TIME_BITS),
    .NUM_BITS (NUM_BITS),
    .FRAC_BITS(SLOPE_FRAC_BITS)
  ) u_div_lo (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.start_calc),
    .num  (num_lo),
    .dvs  (seg_dt),
    .done (lo_done),
    .slope(lo_slope)
  );

  scc_div #(
    .TIME_BITS(TIME_BITS),
    .NUM_BITS (NUM_BITS),
    .FRAC_BITS(SLOPE_FRAC_BITS)
  ) u_div_hi (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.start_calc),
    .num  (num_hi),
    .dvs  (seg_dt),
    .done (hi_done),
    .slope(hi_slope)
  );

  // fitted end only needs state from before this transaction, so it runs alongside
  scc_mul #(
    .A_BITS(SLOPE_W),
    .B_BITS(TIME_BITS)
  ) u_mul (
    .clk    (clk),
    .rst    (rst),
    .start  (cmd.start_calc),
    .a      (mid_mag),
    .b      (fit_dt),
    .done   (mul_done),
    .product(product)
  );

  assign anchor_s = SUM_BITS'(anchor_value);
  assign quot_s   = $signed(SUM_BITS'(product[PROD_BITS-1:SLOPE_FRAC_BITS]));
  assign fit_sum  = mid_neg ? anchor_s - quot_s : anchor_s + quot_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg_we) begin
      tolerance <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cmd_q <= in.cmd;
      t_q   <= in.sample_time;
      v_q   <= in.sample_value;
      dy    <= NUM_BITS'(in.sample_value) - NUM_BITS'(anchor_value);
    end
    if (cmd.start_calc) begin
      early_brk <= t_q <= anchor_time;
      mid_neg   <= slope_sum[MID_W-1];
    end
    if (cmd.fit) begin
      lo_new <= lo_slope;
      hi_new <= hi_slope;
      if (fit_sum > VAL_MAX_S)      fit_value <= VALUE_BITS'(VAL_MAX_S);
      else if (fit_sum < VAL_MIN_S) fit_value <= VALUE_BITS'(VAL_MIN_S);
      else                          fit_value <= VALUE_BITS'(fit_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      anchor_time  <= '0;
      anchor_value <= '0;
      last_time    <= '0;
      slope_low    <= SLOPE_MIN;
      slope_high   <= SLOPE_MAX;
    end else if (cmd.emit_raw) begin
      anchor_time  <= t_q;
      anchor_value <= v_q;
      last_time    <= t_q;
      slope_low    <= SLOPE_MIN;
      slope_high   <= SLOPE_MAX;
    end else if (cmd.emit_end && is_finish) begin
      // fitted end becomes the new anchor
      anchor_time  <= last_time;
      anchor_value <= fit_value;
      slope_low    <= SLOPE_MIN;
      slope_high   <= SLOPE_MAX;
    end else if (cmd.narrow) begin
      if (lo_new > slope_low)  slope_low  <= lo_new;
      if (hi_new < slope_high) slope_high <= hi_new;
      last_time <= t_q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit_end || cmd.emit_raw) begin
      out_valid <= 1'b1;
    end else if (out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_end) begin
      point_time  <= last_time;
      point_value <= fit_value;
      last        <= is_finish;
    end else if (cmd.emit_raw) begin
      point_time  <= t_q;
      point_value <= v_q;
      last        <= 1'b1;
    end
  end

  assign in.ready        = cmd.in_ready;
  assign out.valid       = out_valid;
  assign out.point_time  = point_time;
  assign out.point_value = point_value;
  assign out.last        = last;

  assign status.cmd       = cmd_t'(cmd_q);
  assign status.in_fire   = in_fire;
  assign status.calc_done = lo_done && hi_done && mul_done;
  assign status.brk       = early_brk || (lo_new > slope_high) || (hi_new < slope_low);
  assign status.out_free  = !out_valid || out.ready;

endmodule

@@ rtl/scc_ctrl.sv @@
`timescale 1ns / 1ps
// controller state machine sequencing one transaction at a time
// depends on scc_pkg
module scc_ctrl import scc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  dp_status_t status,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (status.in_fire) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (status.cmd)
          CMD_START:             state_next = ST_EMIT_RAW;
          CMD_SAMPLE, CMD_FINISH: state_next = ST_CALC;
          default:               state_next = ST_IDLE;
        endcase
      end
      ST_CALC: begin
        if (status.calc_done) state_next = ST_FIT;
      end
      ST_FIT: state_next = ST_DECIDE;
      ST_DECIDE: begin
        case (status.cmd)
          CMD_FINISH: state_next = ST_EMIT_END;
          CMD_SAMPLE: state_next = status.brk ? ST_EMIT_END : ST_IDLE;
          default:    state_next = ST_IDLE;
        endcase
      end
      ST_EMIT_END: begin
        if (status.out_free) begin
          state_next = (status.cmd == CMD_FINISH) ? ST_IDLE : ST_EMIT_RAW;
        end
      end
      ST_EMIT_RAW: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE:     cmd.in_ready = 1'b1;
      ST_DISPATCH: begin
        cmd.start_calc = status.cmd inside {CMD_SAMPLE, CMD_FINISH};
      end
      ST_CALC:     cmd = '0;
      ST_FIT:      cmd.fit = 1'b1;
      ST_DECIDE:   cmd.narrow = (status.cmd == CMD_SAMPLE) && !status.brk;
      ST_EMIT_END: cmd.emit_end = status.out_free;
      ST_EMIT_RAW: cmd.emit_raw = status.out_free;
      default:     cmd = '0;
    endcase
  end

endmodule
